[hw/rtl/ia_pkg.sv]
// ia_pkg: shared types and codes for the ID allocator.
// Holds request kinds, status codes, the command word and the back-end states.
// No dependencies.
package ia_pkg;

  localparam int KindWidth   = 2;
  localparam int IdWidth     = 8;
  localparam int StatusWidth = 2;

  localparam logic [KindWidth-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KindWidth-1:0] KIND_FREE   = 2'd1;
  localparam logic [KindWidth-1:0] KIND_QUERY  = 2'd2;
  localparam logic [KindWidth-1:0] KIND_UNUSED = 2'd3;

  localparam logic [StatusWidth-1:0] ST_DONE      = 2'd0;
  localparam logic [StatusWidth-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [StatusWidth-1:0] ST_IGNORED   = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_QUERY,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IdWidth-1:0] id;
  } cmd_t;

  typedef enum logic {
    BK_ISSUE,
    BK_EXEC
  } bk_state_t;

endpackage

[hw/rtl/ia_ram.sv]
// ia_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/ia_front.sv]
// ia_front: accepts requests and classifies them into command words.
// Depends on ia_pkg.
module ia_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ia_pkg::KindWidth-1:0] in_kind,
  input  logic [ia_pkg::IdWidth-1:0]   in_id,
  output logic                         push_valid,
  input  logic                         push_ready,
  output ia_pkg::cmd_t                 push_cmd
);
  import ia_pkg::*;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_cmd.id = in_id;
    unique case (in_kind)
      KIND_ALLOC:  push_cmd.op = OP_ALLOC;
      KIND_FREE:   push_cmd.op = OP_FREE;
      KIND_QUERY:  push_cmd.op = OP_QUERY;
      KIND_UNUSED: push_cmd.op = OP_NOP;
      default:     push_cmd.op = OP_NOP;
    endcase
  end

endmodule

[hw/rtl/ia_cmd_queue.sv]
// ia_cmd_queue: two-entry command queue between front and back end.
// Depends on ia_pkg.
module ia_cmd_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  ia_pkg::cmd_t push_cmd,
  output logic         pop_valid,
  input  logic         pop_ready,
  output ia_pkg::cmd_t pop_cmd
);
  import ia_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/ia_back.sv]
// ia_back: executes allocate, free and query commands against the free list,
// the allocation map and the high-water counter. Depends on ia_pkg, ia_ram.
module ia_back #(
  parameter int NUM_IDS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  ia_pkg::cmd_t                   pop_cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ia_pkg::IdWidth-1:0]     out_granted_id,
  output logic [ia_pkg::StatusWidth-1:0] out_status,
  output logic                           out_in_use
);
  import ia_pkg::*;

  localparam int IDX_W  = $clog2(NUM_IDS);
  localparam int HEAD_W = $clog2(NUM_IDS + 1);
  localparam int CMP_W  = (HEAD_W > IdWidth) ? HEAD_W : IdWidth;

  bk_state_t               state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [HEAD_W-1:0]       head_r, head_nxt;
  logic [HEAD_W-1:0]       hw_r, hw_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IdWidth-1:0]      granted_r, granted_nxt;
  logic [StatusWidth-1:0]  status_r, status_nxt;
  logic                    alloc_bit_r, alloc_bit_nxt;

  logic                    issue, fire;
  logic [CMP_W-1:0]        pop_id_ext, cmd_id_ext;
  logic                    head_empty, is_alloc;
  logic [HEAD_W-1:0]       got;

  logic                    link_we;
  logic [IDX_W-1:0]        link_waddr;
  logic [HEAD_W-1:0]       link_wdata;
  logic [HEAD_W-1:0]       link_rdata;
  logic                    map_we;
  logic [IDX_W-1:0]        map_waddr;
  logic                    map_wdata;
  logic                    map_rdata;

  assign pop_id_ext = CMP_W'(pop_cmd.id);
  assign cmd_id_ext = CMP_W'(cmd_r.id);
  assign head_empty = (head_r == HEAD_W'(NUM_IDS));
  // map entries at or above the high-water mark were never written: read as clear
  assign is_alloc   = (cmd_id_ext < CMP_W'(NUM_IDS)) && (cmd_id_ext < CMP_W'(hw_r)) && map_rdata;

  ia_ram #(
    .WIDTH (HEAD_W),
    .DEPTH (NUM_IDS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (issue),
    .raddr (head_r[IDX_W-1:0]),
    .rdata (link_rdata)
  );

  ia_ram #(
    .WIDTH (1),
    .DEPTH (NUM_IDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (issue),
    .raddr (pop_id_ext[IDX_W-1:0]),
    .rdata (map_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    head_nxt      = head_r;
    hw_nxt        = hw_r;
    granted_nxt   = granted_r;
    status_nxt    = status_r;
    alloc_bit_nxt = alloc_bit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pop_ready     = 1'b0;
    issue         = 1'b0;
    fire          = 1'b0;
    got           = '0;
    link_we       = 1'b0;
    link_waddr    = cmd_id_ext[IDX_W-1:0];
    link_wdata    = head_r;
    map_we        = 1'b0;
    map_waddr     = cmd_id_ext[IDX_W-1:0];
    map_wdata     = 1'b0;

    unique case (state_r)
      BK_ISSUE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          issue     = 1'b1;
          cmd_nxt   = pop_cmd;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        fire = !out_valid_r || out_ready;
        if (fire) begin
          state_nxt     = BK_ISSUE;
          out_valid_nxt = 1'b1;
          granted_nxt   = '0;
          status_nxt    = ST_DONE;
          alloc_bit_nxt = 1'b0;
          unique case (cmd_r.op)
            OP_ALLOC: begin
              priority if (!head_empty) begin
                got      = head_r;
                head_nxt = link_rdata;
              end else if (hw_r != HEAD_W'(NUM_IDS)) begin
                got    = hw_r;
                hw_nxt = hw_r + HEAD_W'(1);
              end else begin
                status_nxt = ST_EXHAUSTED;
              end
              if (status_nxt == ST_DONE) begin
                granted_nxt = IdWidth'(got);
                map_we      = 1'b1;
                map_waddr   = got[IDX_W-1:0];
                map_wdata   = 1'b1;
              end
            end
            OP_FREE: begin
              if (is_alloc) begin
                map_we   = 1'b1;
                link_we  = 1'b1;
                head_nxt = cmd_id_ext[HEAD_W-1:0];
              end else begin
                status_nxt = ST_IGNORED;
              end
            end
            OP_QUERY: begin
              alloc_bit_nxt = is_alloc;
            end
            OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = BK_ISSUE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_ISSUE;
      head_r      <= HEAD_W'(NUM_IDS);
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    granted_r   <= granted_nxt;
    status_r    <= status_nxt;
    alloc_bit_r <= alloc_bit_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_granted_id = granted_r;
  assign out_status     = status_r;
  assign out_in_use     = alloc_bit_r;

endmodule

[hw/rtl/id_allocator_with_reuse_top.sv]
// id_allocator_with_reuse_top: LIFO free-list ID allocator with reuse.
// Path: queue slot, back-end issue state, back-end execute state, output registers.
// Each request is issued (link/map RAM read) and executed before the next is taken.
// Reset: free list empty, high-water count zero, all IDs free; no clearing pass is needed.
// Depends on ia_pkg, ia_front, ia_cmd_queue, ia_back, ia_ram.
module id_allocator_with_reuse_top #(
  parameter int NUM_IDS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ia_pkg::KindWidth-1:0]   in_kind,
  input  logic [ia_pkg::IdWidth-1:0]     in_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ia_pkg::IdWidth-1:0]     out_granted_id,
  output logic [ia_pkg::StatusWidth-1:0] out_status,
  output logic                           out_in_use
);
  import ia_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  ia_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_id      (in_id),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  ia_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  ia_back #(
    .NUM_IDS (NUM_IDS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_cmd        (pop_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_granted_id (out_granted_id),
    .out_status     (out_status),
    .out_in_use     (out_in_use)
  );

endmodule
